// ===== rtl/sftl_pkg.sv =====
// Shared constants and types for the sorted fix-up table lookup block.
package sftl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 64;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_SEAL   = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_SEALED   = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] fault;
      logic [ADDR_W-1:0] recovery;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_addr;
   } store_req_type;

endpackage

// ===== rtl/sftl_store.sv =====
// Pair store: one write port, one read port with registered read data.
module sftl_store (
   input  logic                   clock,
   input  sftl_pkg::store_req_type req,
   output sftl_pkg::entry_type     rd_data
);
   import sftl_pkg::*;

   entry_type entry_mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         entry_mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= entry_mem[req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sorted_fixup_table_lookup.sv =====
// Top level of the sorted fix-up table: command decode, sort and search sequencer.
//
// Usage: drive req_kind, req_fault_addr and req_recovery_addr and raise start; the
// beat is taken at a clock edge where start is high and busy is low. Every beat gives
// exactly one result beat on rsp_recovery, rsp_found and rsp_status, marked by
// rsp_strobe for one cycle. The receiver cannot stall; results are never held.
// How each kind is served, from the accepting edge to the result:
//   load, unused kind, refused seal, lookup on an empty table : answered from idle
//   lookup on a sealed table of n    : binary search for the lowest entry not below the
//                                      key; one read of the pair store per step
//   lookup before sealing            : a linear scan from entry 0, one read per cycle,
//                                      ending at the first match or after entry n - 1
//   seal                             : insertion sort in place by fault address; with
//                                      under 2 entries the table is just marked sealed
// busy is high while a lookup or sort walks the store; the next beat can be taken in
// the cycle the previous result is shown. The pair store uses a single read and a
// single write port with registered read data.
// Reset clears the count, the ready and overflow flags and the sequencer; the pair
// store is not cleared, only entries below the count are ever read.
module sorted_fixup_table_lookup (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [sftl_pkg::ADDR_W-1:0] req_fault_addr,
   input  logic [sftl_pkg::ADDR_W-1:0] req_recovery_addr,
   output logic                        rsp_strobe,
   output logic [sftl_pkg::ADDR_W-1:0] rsp_recovery,
   output logic                        rsp_found,
   output logic [1:0]                  rsp_status
);
   import sftl_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SORT_KEY = 3'd1;
   localparam logic [2:0] S_SORT_CMP = 3'd2;
   localparam logic [2:0] S_SORT_PUT = 3'd3;
   localparam logic [2:0] S_LIN      = 3'd4;
   localparam logic [2:0] S_BIN      = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ready_ff, ready_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   entry_type         key_ff, key_in;
   entry_type         cand_ff, cand_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [ADDR_W-1:0] rsp_recovery_ff, rsp_recovery_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   store_req_type     sreq;
   entry_type         rdata;

   logic [CNT_W-1:0]  mid;
   logic [CNT_W-1:0]  lo_nx;
   logic [CNT_W-1:0]  hi_nx;
   logic [CNT_W-1:0]  mid_nx;
   logic [CNT_W-1:0]  i_next;
   entry_type         cand_nx;
   logic              advance;

   sftl_store u_store (
      .clock   (clock),
      .req     (sreq),
      .rd_data (rdata)
   );

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ready_in        = ready_ff;
      ovf_in          = ovf_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      key_in          = key_ff;
      cand_in         = cand_ff;
      rsp_strobe_in   = 1'b0;
      rsp_recovery_in = '0;
      rsp_found_in    = 1'b0;
      rsp_status_in   = ST_OK;
      sreq            = '0;
      advance         = 1'b0;
      mid             = lo_ff + ((hi_ff - lo_ff) >> 1);
      lo_nx           = lo_ff;
      hi_nx           = hi_ff;
      mid_nx          = '0;
      cand_nx         = cand_ff;
      i_next          = CNT_W'(i_ff) + 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_LOAD: begin
                     rsp_strobe_in = 1'b1;
                     if (ready_ff) begin
                        rsp_status_in = ST_SEALED;
                     end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        sreq.wr_en   = 1'b1;
                        sreq.wr_addr = count_ff[IDX_W-1:0];
                        sreq.wr_data = '{fault: req_fault_addr, recovery: req_recovery_addr};
                        count_in     = count_ff + 1'b1;
                     end else begin
                        ovf_in        = 1'b1;
                        rsp_status_in = ST_OVERFLOW;
                     end
                  end
                  KIND_SEAL: begin
                     if (ready_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_SEALED;
                     end else if (ovf_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_OVERFLOW;
                     end else if (count_ff < CNT_W'(2)) begin
                        rsp_strobe_in = 1'b1;
                        ready_in      = 1'b1;
                     end else begin
                        i_in         = IDX_W'(1);
                        sreq.rd_addr = IDX_W'(1);
                        state_in     = S_SORT_KEY;
                     end
                  end
                  KIND_LOOKUP: begin
                     key_in.fault = req_fault_addr;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else if (ready_ff) begin
                        lo_in        = '0;
                        hi_in        = count_ff;
                        mid_nx       = count_ff >> 1;
                        sreq.rd_addr = mid_nx[IDX_W-1:0];
                        state_in     = S_BIN;
                     end else begin
                        i_in         = '0;
                        sreq.rd_addr = '0;
                        state_in     = S_LIN;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_SORT_KEY: begin
            key_in       = rdata;
            j_in         = i_ff;
            sreq.rd_addr = i_ff - 1'b1;
            state_in     = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            sreq.wr_en   = 1'b1;
            sreq.wr_addr = j_ff;
            if (rdata.fault > key_ff.fault) begin
               sreq.wr_data = rdata;
               j_in         = j_ff - 1'b1;
               if (j_ff > IDX_W'(1)) begin
                  sreq.rd_addr = j_ff - IDX_W'(2);
               end else begin
                  state_in = S_SORT_PUT;
               end
            end else begin
               sreq.wr_data = key_ff;
               advance      = 1'b1;
            end
         end
         S_SORT_PUT: begin
            sreq.wr_en   = 1'b1;
            sreq.wr_addr = j_ff;
            sreq.wr_data = key_ff;
            advance      = 1'b1;
         end
         S_LIN: begin
            if (rdata.fault == key_ff.fault) begin
               rsp_strobe_in   = 1'b1;
               rsp_recovery_in = rdata.recovery;
               rsp_found_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (i_next < count_ff) begin
               i_in         = i_next[IDX_W-1:0];
               sreq.rd_addr = i_next[IDX_W-1:0];
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_BIN: begin
            if (rdata.fault < key_ff.fault) begin
               lo_nx = mid + 1'b1;
            end else begin
               hi_nx   = mid;
               cand_nx = rdata;
            end
            lo_in   = lo_nx;
            hi_in   = hi_nx;
            cand_in = cand_nx;
            mid_nx  = lo_nx + ((hi_nx - lo_nx) >> 1);
            if (lo_nx < hi_nx) begin
               sreq.rd_addr = mid_nx[IDX_W-1:0];
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (hi_nx < count_ff && cand_nx.fault == key_ff.fault) begin
                  rsp_recovery_in = cand_nx.recovery;
                  rsp_found_in    = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // next element of the sort, or finish
      if (advance) begin
         if (i_next < count_ff) begin
            i_in         = i_next[IDX_W-1:0];
            sreq.rd_addr = i_next[IDX_W-1:0];
            state_in     = S_SORT_KEY;
         end else begin
            ready_in      = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         ready_ff      <= 1'b0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ready_ff      <= ready_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff            <= i_in;
      j_ff            <= j_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      key_ff          <= key_in;
      cand_ff         <= cand_in;
      rsp_recovery_ff <= rsp_recovery_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_recovery = rsp_recovery_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_status   = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_ready_no_ovf: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> !ovf_ff)
      else $error("sealed table carries overflow");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result beat while an item is still in work");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> (rsp_status == ST_OK))
      else $error("hit reported with non-ok status");

endmodule
